>>> hw/rtl/ert_pkg.sv
// Shared types and constants of the echo reply tracker.
`default_nettype none

package ert_pkg;

    localparam int DUP_BITS  = 1024;
    localparam int SLOT_W    = $clog2(DUP_BITS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DUP_BITS - 1);

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 296;

    localparam int CNT_W  = 32;
    localparam int TRIP_W = 40;
    localparam int SUM_W  = 48;

    localparam logic [CFG_IDX_W-1:0] REG_MY_ID      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = CFG_IDX_W'(1);
    localparam logic [15:0]          MIN_LENGTH_RST = 16'd64;

    localparam logic [7:0] MSG_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] MSG_ECHO_REQUEST = 8'd8;

    typedef enum logic [2:0] {
        ST_SENT      = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_NOT_OURS  = 3'd2,
        ST_REPLY     = 3'd3,
        ST_DUP_REPLY = 3'd4,
        ST_OTHER     = 3'd5,
        ST_OWN_REQ   = 3'd6
    } status_t;

    typedef struct packed {
        logic        op;
        logic [15:0] total_length;
        logic [3:0]  header_words;
        logic [7:0]  msg_type;
        logic [15:0] echo_ident;
        logic [15:0] echo_seq;
        logic [31:0] sent_sec;
        logic [19:0] sent_usec;
        logic [31:0] now_sec;
        logic [19:0] now_usec;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [15:0]       seq_out;
        logic [15:0]       payload_bytes;
        logic [TRIP_W-1:0] trip_time;
        logic [CNT_W-1:0]  sent_count;
        logic [CNT_W-1:0]  received_count;
        logic [CNT_W-1:0]  duplicate_count;
        logic [TRIP_W-1:0] min_trip;
        logic [TRIP_W-1:0] max_trip;
        logic [SUM_W-1:0]  trip_sum;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic              data;
    } dup_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/ert_dup_table.sv
// Duplicate bitmap memory with post-reset clearing pass and write forwarding.
`default_nettype none

module ert_dup_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [ert_pkg::SLOT_W-1:0] rd_addr,
    input  wire ert_pkg::dup_wr_t          wr,
    input  wire logic                      wr_en,
    output logic                           seen,
    output logic                           busy
);
    import ert_pkg::*;

    logic              mem [DUP_BITS];
    logic              rd_data_reg;
    logic              fwd_vld_reg;
    logic              fwd_bit_reg;
    logic              clr_busy_reg;
    logic [SLOT_W-1:0] clr_idx_reg;

    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic              wdata;
    logic              item_we;

    assign item_we = wr_en && wr.we;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            we    = 1'b1;
            waddr = clr_idx_reg;
            wdata = 1'b0;
        end
        else
        begin
            we    = item_we;
            waddr = wr.addr;
            wdata = wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            fwd_vld_reg  <= 1'b0;
            fwd_bit_reg  <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= SLOT_W'(clr_idx_reg + 1'b1);
                if (clr_idx_reg == SLOT_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            // forward a write landing on the slot being read in the same cycle
            if (rd_en)
            begin
                fwd_vld_reg <= item_we && (wr.addr == rd_addr);
                fwd_bit_reg <= wr.data;
            end
        end
    end

    assign seen = fwd_vld_reg ? fwd_bit_reg : rd_data_reg;
    assign busy = clr_busy_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ert_trip_calc.sv
// Round-trip time in 100 microsecond ticks from send and receive timestamps.
`default_nettype none

module ert_trip_calc (
    input  wire logic [31:0]              sent_sec,
    input  wire logic [19:0]              sent_usec,
    input  wire logic [31:0]              now_sec,
    input  wire logic [19:0]              now_usec,
    output logic [ert_pkg::TRIP_W-1:0]    trip
);
    import ert_pkg::*;

    localparam int USEC_PER_TICK = 100;
    localparam int DIV_SHIFT     = 28;
    localparam logic [42:0] DIV_RECIP =
        43'(((64'd1 << DIV_SHIFT) + USEC_PER_TICK - 1) / USEC_PER_TICK);
    localparam logic signed [21:0] USEC_PER_SEC  = 22'sd1000000;
    localparam logic signed [49:0] TICKS_PER_SEC = 50'sd10000;

    logic signed [33:0] dsec;
    logic signed [33:0] dsec_adj;
    logic signed [21:0] dus;
    logic signed [21:0] dus_adj;
    logic               borrow;
    logic               neg;
    logic [20:0]        mag;
    logic [42:0]        prod;
    logic [13:0]        quot;
    logic signed [49:0] ticks;
    logic signed [49:0] total;

    always_comb
    begin
        dsec     = $signed({2'b00, now_sec}) - $signed({2'b00, sent_sec});
        dus      = $signed({2'b00, now_usec}) - $signed({2'b00, sent_usec});
        borrow   = dus[21];
        dsec_adj = dsec - $signed({33'd0, borrow});
        dus_adj  = borrow ? dus + USEC_PER_SEC : dus;
        // divide by 100 truncating toward zero
        neg      = dus_adj[21];
        mag      = neg ? 21'(-dus_adj) : 21'(dus_adj);
        prod     = 43'(mag) * DIV_RECIP;
        quot     = 14'(prod >> DIV_SHIFT);
        ticks    = $signed({{16{dsec_adj[33]}}, dsec_adj}) * TICKS_PER_SEC;
        total    = neg ? ticks - $signed({36'd0, quot}) : ticks + $signed({36'd0, quot});
        if (total[49])
        begin
            trip = '0;
        end
        else if (|total[48:TRIP_W])
        begin
            trip = '1;
        end
        else
        begin
            trip = total[TRIP_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ert_update.sv
// Packet classification and saturating statistics registers.
`default_nettype none

module ert_update (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     adv,
    input  wire ert_pkg::item_t           item,
    input  wire logic [15:0]              my_id,
    input  wire logic [15:0]              min_length,
    input  wire logic                     seen,
    input  wire logic [ert_pkg::TRIP_W-1:0] trip,
    output ert_pkg::result_t              res,
    output ert_pkg::dup_wr_t              wr
);
    import ert_pkg::*;

    logic [CNT_W-1:0]  tx_reg,  tx_next;
    logic [CNT_W-1:0]  rx_reg,  rx_next;
    logic [CNT_W-1:0]  dup_reg, dup_next;
    logic [TRIP_W-1:0] min_reg, min_next;
    logic [TRIP_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    logic [5:0]        hbytes;
    logic [15:0]       payload;
    logic [SUM_W:0]    sum_wide;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : CNT_W'(c + 1'b1);
    endfunction

    always_comb
    begin
        hbytes   = {item.header_words, 2'b00};
        payload  = (item.total_length >= {10'd0, hbytes}) ?
                   16'(item.total_length - {10'd0, hbytes}) : 16'd0;
        sum_wide = {1'b0, sum_reg} + {{(SUM_W - TRIP_W + 1){1'b0}}, trip};

        tx_next  = tx_reg;
        rx_next  = rx_reg;
        dup_next = dup_reg;
        min_next = min_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        wr       = '0;

        res               = '0;
        res.status        = ST_SENT;

        if (!item.op)
        begin
            res.seq_out = tx_reg[15:0];
            wr.we       = 1'b1;
            wr.addr     = tx_reg[SLOT_W-1:0];
            wr.data     = 1'b0;
            tx_next     = sat_inc(tx_reg);
        end
        else
        begin
            res.seq_out       = item.echo_seq;
            res.payload_bytes = payload;
            if (item.total_length < min_length)
            begin
                res.status = ST_TOO_SHORT;
            end
            else if (item.echo_ident != my_id)
            begin
                res.status = ST_NOT_OURS;
            end
            else if (item.msg_type == MSG_ECHO_REPLY)
            begin
                res.trip_time = trip;
                sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                min_next = (trip < min_reg) ? trip : min_reg;
                max_next = (trip > max_reg) ? trip : max_reg;
                if (seen)
                begin
                    dup_next   = sat_inc(dup_reg);
                    res.status = ST_DUP_REPLY;
                end
                else
                begin
                    wr.we      = 1'b1;
                    wr.addr    = item.echo_seq[SLOT_W-1:0];
                    wr.data    = 1'b1;
                    rx_next    = sat_inc(rx_reg);
                    res.status = ST_REPLY;
                end
            end
            else if (item.msg_type == MSG_ECHO_REQUEST)
            begin
                res.status = ST_OWN_REQ;
            end
            else
            begin
                res.status = ST_OTHER;
            end
        end

        res.sent_count      = tx_next;
        res.received_count  = rx_next;
        res.duplicate_count = dup_next;
        res.min_trip        = min_next;
        res.max_trip        = max_next;
        res.trip_sum        = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg  <= '0;
            rx_reg  <= '0;
            dup_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
            sum_reg <= '0;
        end
        else if (adv)
        begin
            tx_reg  <= tx_next;
            rx_reg  <= rx_next;
            dup_reg <= dup_next;
            min_reg <= min_next;
            max_reg <= max_next;
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/echo_reply_tracker_core.sv
// Echo reply tracker top level: input stage, result register, configuration.
//
// Input words arrive on s_axis: tuser carries op (0 send, 1 received packet),
// tdata the packet fields. Each accepted word yields exactly one result word
// on m_axis, with the status code in tuser and the updated statistics in tdata.
// Registers my_id (index 0) and min_length (index 1) are written on the cfg
// channel, which is always ready; write them only while the block is idle.
// A word that is accepted is registered in the input stage, and its result is
// loaded into the output register when the input stage advances.
// Throughput: one word per cycle unless m_axis_tready stalls it, set by the
// single pass from the input stage through the trip arithmetic and the bitmap
// read-modify-write. After reset the duplicate bitmap is swept to zero, one bit
// per cycle over all 1024 bits; s_axis_tready stays low until the sweep ends.
// When m_axis_tready is low the output register holds, the input stage holds
// one more word, and then s_axis_tready drops until the result is taken.
`default_nettype none

module echo_reply_tracker_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // total_length, header_words, msg_type, echo_ident, echo_seq,
    // sent_sec, sent_usec, now_sec, now_usec, zero pad
    input  wire logic [ert_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  wire logic [0:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // seq_out, payload_bytes, trip_time, sent_count, received_count,
    // duplicate_count, min_trip, max_trip, trip_sum
    output logic [ert_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // status
    output logic [2:0]                           m_axis_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ert_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ert_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import ert_pkg::*;

    item_t             in_item;
    item_t             st_item_reg;
    logic              st_vld_reg;
    result_t           out_res_reg;
    logic              out_vld_reg;
    logic [15:0]       my_id_reg;
    logic [15:0]       min_len_reg;

    logic              accept;
    logic              adv;
    logic              seen;
    logic              clr_busy;
    logic [TRIP_W-1:0] trip;
    result_t           res;
    dup_wr_t           wr;

    assign in_item.op           = s_axis_tuser[0];
    assign in_item.total_length = s_axis_tdata[15:0];
    assign in_item.header_words = s_axis_tdata[19:16];
    assign in_item.msg_type     = s_axis_tdata[27:20];
    assign in_item.echo_ident   = s_axis_tdata[43:28];
    assign in_item.echo_seq     = s_axis_tdata[59:44];
    assign in_item.sent_sec     = s_axis_tdata[91:60];
    assign in_item.sent_usec    = s_axis_tdata[111:92];
    assign in_item.now_sec      = s_axis_tdata[143:112];
    assign in_item.now_usec     = s_axis_tdata[163:144];

    assign adv           = st_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !clr_busy && (!st_vld_reg || adv);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    ert_dup_table u_dup_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_item.echo_seq[SLOT_W-1:0]),
        .wr      (wr),
        .wr_en   (adv),
        .seen    (seen),
        .busy    (clr_busy)
    );

    ert_trip_calc u_trip_calc (
        .sent_sec  (st_item_reg.sent_sec),
        .sent_usec (st_item_reg.sent_usec),
        .now_sec   (st_item_reg.now_sec),
        .now_usec  (st_item_reg.now_usec),
        .trip      (trip)
    );

    ert_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item       (st_item_reg),
        .my_id      (my_id_reg),
        .min_length (min_len_reg),
        .seen       (seen),
        .trip       (trip),
        .res        (res),
        .wr         (wr)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_item_reg <= in_item;
        end
        if (adv)
        begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            my_id_reg   <= '0;
            min_len_reg <= MIN_LENGTH_RST;
        end
        else
        begin
            if (accept)
            begin
                st_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                st_vld_reg <= 1'b0;
            end

            if (adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MY_ID:      my_id_reg   <= cfg_data;
                    REG_MIN_LENGTH: min_len_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {out_res_reg.trip_sum,
                            out_res_reg.max_trip,
                            out_res_reg.min_trip,
                            out_res_reg.duplicate_count,
                            out_res_reg.received_count,
                            out_res_reg.sent_count,
                            out_res_reg.trip_time,
                            out_res_reg.payload_bytes,
                            out_res_reg.seq_out};

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy |-> !s_axis_tready)
        else $error("input accepted during bitmap sweep");

    a_stage_holds_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (st_vld_reg && !adv) |=> (st_vld_reg && $stable(st_item_reg)))
        else $error("input stage lost a word while stalled");

    a_dup_needs_seen_bit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (adv && res.status == ST_DUP_REPLY) |-> (seen && !wr.we))
        else $error("duplicate reply without a set bitmap bit");

    a_min_below_max: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_res_reg.received_count != '0 ||
                         out_res_reg.duplicate_count != '0))
        |-> (out_res_reg.min_trip <= out_res_reg.max_trip))
        else $error("min trip above max trip after a reply");

endmodule

`default_nettype wire

>>> bench/echo_reply_tracker_core_test.sv
// Self-checking bench for the echo reply tracker: predicted statistics against every result word.
module echo_reply_tracker_core_test;
    import ert_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    echo_reply_tracker_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    logic [15:0]       id_reg = 16'd0;
    logic [15:0]       min_len_reg = MIN_LENGTH_RST;
    bit                seen_map [DUP_BITS];
    logic [CNT_W-1:0]  tx_count = '0;
    logic [CNT_W-1:0]  rx_count = '0;
    logic [CNT_W-1:0]  dup_count = '0;
    logic [TRIP_W-1:0] trip_lo = '1;
    logic [TRIP_W-1:0] trip_hi = '0;
    logic [SUM_W-1:0]  trip_acc = '0;

    item_t   packets_pending [$];
    result_t stats_due [$];
    item_t   offered;
    int      send_idle = 24;
    int      recv_idle = 71;
    int      words_queued = 0;
    int      words_checked = 0;
    int      mismatches = 0;
    logic [31:0] gen_sent = '0;

    function automatic logic [TRIP_W-1:0] round_trip(input item_t it);
        longint a;
        longint b;
        longint dsec;
        longint dus;
        longint t;
        a = it.now_sec;
        b = it.sent_sec;
        dsec = a - b;
        a = it.now_usec;
        b = it.sent_usec;
        dus = a - b;
        if (dus < 0)
        begin
            dsec = dsec - 1;
            dus = dus + 1000000;
        end
        t = dsec * 10000 + dus / 100;
        if (t < 0)
            return '0;
        if (t > 64'h0000_00FF_FFFF_FFFF)
            return '1;
        return t[TRIP_W-1:0];
    endfunction

    function automatic result_t track_packet(input item_t it);
        result_t           r;
        logic [15:0]       hbytes;
        logic [SLOT_W-1:0] slot;
        logic [SUM_W:0]    acc;
        r = '0;
        if (it.op == 1'b0)
        begin
            r.status = ST_SENT;
            r.seq_out = tx_count[15:0];
            seen_map[tx_count[SLOT_W-1:0]] = 1'b0;
            if (tx_count != '1)
                tx_count = tx_count + 1'b1;
        end
        else
        begin
            hbytes = {10'd0, it.header_words, 2'b00};
            r.seq_out = it.echo_seq;
            r.payload_bytes = (it.total_length >= hbytes) ? it.total_length - hbytes : '0;
            if (it.total_length < min_len_reg)
                r.status = ST_TOO_SHORT;
            else if (it.echo_ident != id_reg)
                r.status = ST_NOT_OURS;
            else if (it.msg_type == MSG_ECHO_REPLY)
            begin
                r.trip_time = round_trip(it);
                acc = {1'b0, trip_acc} + r.trip_time;
                trip_acc = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
                if (r.trip_time < trip_lo)
                    trip_lo = r.trip_time;
                if (r.trip_time > trip_hi)
                    trip_hi = r.trip_time;
                slot = it.echo_seq[SLOT_W-1:0];
                if (seen_map[slot])
                begin
                    if (dup_count != '1)
                        dup_count = dup_count + 1'b1;
                    r.status = ST_DUP_REPLY;
                end
                else
                begin
                    seen_map[slot] = 1'b1;
                    if (rx_count != '1)
                        rx_count = rx_count + 1'b1;
                    r.status = ST_REPLY;
                end
            end
            else if (it.msg_type == MSG_ECHO_REQUEST)
                r.status = ST_OWN_REQ;
            else
                r.status = ST_OTHER;
        end
        r.sent_count = tx_count;
        r.received_count = rx_count;
        r.duplicate_count = dup_count;
        r.min_trip = trip_lo;
        r.max_trip = trip_hi;
        r.trip_sum = trip_acc;
        return r;
    endfunction

    function automatic item_t any_item();
        item_t it;
        it.op = 1'($urandom_range(0, 1));
        it.total_length = 16'($urandom);
        it.header_words = 4'($urandom);
        it.msg_type = 8'($urandom);
        it.echo_ident = 16'($urandom);
        it.echo_seq = 16'($urandom);
        it.sent_sec = $urandom;
        it.sent_usec = 20'($urandom);
        it.now_sec = $urandom;
        it.now_usec = 20'($urandom);
        return it;
    endfunction

    function automatic item_t echo_reply(input logic [15:0] seq, input logic [31:0] ss,
                                         input logic [19:0] su, input logic [31:0] ns,
                                         input logic [19:0] nu);
        item_t it;
        it = '0;
        it.op = 1'b1;
        it.total_length = 16'd84;
        it.header_words = 4'd5;
        it.msg_type = MSG_ECHO_REPLY;
        it.echo_ident = id_reg;
        it.echo_seq = seq;
        it.sent_sec = ss;
        it.sent_usec = su;
        it.now_sec = ns;
        it.now_usec = nu;
        return it;
    endfunction

    function automatic item_t make_item();
        item_t       it;
        int          pick;
        logic [16:0] len;
        logic [31:0] seq;
        pick = $urandom_range(0, 99);
        it = any_item();
        if (pick < 30)
        begin
            it.op = 1'b0;
            return it;
        end
        it.op = 1'b1;
        if (pick >= 85)
        begin
            case ($urandom_range(0, 3))
                0: it.msg_type = MSG_ECHO_REPLY;
                1: it.msg_type = MSG_ECHO_REQUEST;
                default: ;
            endcase
            if ($urandom_range(0, 1) == 0)
                it.echo_ident = id_reg;
            return it;
        end
        it.msg_type = MSG_ECHO_REPLY;
        it.echo_ident = id_reg;
        len = {1'b0, min_len_reg} + 17'($urandom_range(0, 1500));
        it.total_length = len[16] ? 16'hFFFF : len[15:0];
        it.header_words = 4'($urandom_range(5, 15));
        if (gen_sent == 0)
            seq = $urandom;
        else
            seq = gen_sent - 1 - $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0)
            seq = seq + DUP_BITS;
        it.echo_seq = seq[15:0];
        it.sent_usec = 20'($urandom_range(0, 999999));
        it.now_usec = 20'($urandom_range(0, 999999));
        case ($urandom_range(0, 9))
            7: it.now_sec = it.sent_sec - $urandom_range(1, 3);
            8: ;
            9:
            begin
                it.sent_usec = 20'($urandom);
                it.now_usec = 20'($urandom);
                it.now_sec = it.sent_sec + $urandom_range(0, 1);
            end
            default: it.now_sec = it.sent_sec + $urandom_range(0, 2);
        endcase
        if (pick >= 75)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    if (min_len_reg != 16'd0)
                        it.total_length = 16'($urandom_range(0, min_len_reg - 1));
                end
                1: it.echo_ident = it.echo_ident ^ 16'($urandom_range(1, 65535));
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        it.msg_type = MSG_ECHO_REQUEST;
                    else
                        it.msg_type = 8'($urandom_range(1, 255));
                end
            endcase
        end
        return it;
    endfunction

    task automatic queue_item(input item_t it);
        packets_pending.push_back(it);
        words_queued++;
        if (it.op == 1'b0)
            gen_sent = gen_sent + 1;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            queue_item(make_item());
    endtask

    task automatic drain();
        while (words_checked != words_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MY_ID)
            id_reg = val;
        else if (idx == REG_MIN_LENGTH)
            min_len_reg = val;
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                stats_due.push_back(track_packet(offered));
            if (packets_pending.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                offered = packets_pending.pop_front();
                s_axis_tdata <= {4'd0, offered.now_usec, offered.now_sec, offered.sent_usec,
                                 offered.sent_sec, offered.echo_seq, offered.echo_ident,
                                 offered.msg_type, offered.header_words,
                                 offered.total_length};
                s_axis_tuser <= offered.op;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin : watch
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (stats_due.size() == 0)
                flag_mismatch("unexpected word", {61'd0, m_axis_tuser}, '0);
            else
            begin
                want = stats_due.pop_front();
                check_field("status", m_axis_tuser, want.status);
                check_field("seq_out", m_axis_tdata[15:0], want.seq_out);
                check_field("payload_bytes", m_axis_tdata[31:16], want.payload_bytes);
                check_field("trip_time", m_axis_tdata[71:32], want.trip_time);
                check_field("sent_count", m_axis_tdata[103:72], want.sent_count);
                check_field("received_count", m_axis_tdata[135:104], want.received_count);
                check_field("duplicate_count", m_axis_tdata[167:136], want.duplicate_count);
                check_field("min_trip", m_axis_tdata[207:168], want.min_trip);
                check_field("max_trip", m_axis_tdata[247:208], want.max_trip);
                check_field("trip_sum", m_axis_tdata[295:248], want.trip_sum);
                words_checked++;
            end
        end
    end

    initial
    begin
        item_t d;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(REG_MY_ID, 16'h0000);
        write_reg(REG_MIN_LENGTH, MIN_LENGTH_RST);

        d = '0;
        queue_item(d);
        queue_item(d);
        queue_item(d);
        queue_item(echo_reply(16'd0, 32'd100, 20'd0, 32'd100, 20'd12345));
        queue_item(echo_reply(16'd0, 32'd100, 20'd0, 32'd100, 20'd12345));
        queue_item(echo_reply(16'd1, 32'd5, 20'd999999, 32'd7, 20'd0));
        queue_item(echo_reply(16'd2, 32'd10, 20'd0, 32'd9, 20'd500000));
        queue_item(echo_reply(16'd1026, 32'd0, 20'd0, 32'hFFFF_FFFF, 20'd999999));
        queue_item(echo_reply(16'd3, 32'd0, 20'hFFFFF, 32'd0, 20'd0));
        queue_item(echo_reply(16'd4, 32'd0, 20'd0, 32'd0, 20'hFFFFF));
        d = echo_reply(16'd5, 32'd1, 20'd0, 32'd1, 20'd200);
        d.total_length = 16'd10;
        d.header_words = 4'd15;
        queue_item(d);
        d.total_length = 16'd63;
        d.header_words = 4'd0;
        queue_item(d);
        d = echo_reply(16'd6, 32'd1, 20'd0, 32'd1, 20'd100);
        d.total_length = 16'd64;
        d.header_words = 4'd0;
        queue_item(d);
        d = echo_reply(16'd7, 32'd1, 20'd0, 32'd2, 20'd0);
        d.echo_ident = 16'hFFFF;
        queue_item(d);
        d.echo_ident = id_reg;
        d.msg_type = MSG_ECHO_REQUEST;
        queue_item(d);
        d.msg_type = 8'hFF;
        queue_item(d);
        d.msg_type = 8'h01;
        queue_item(d);
        d = echo_reply(16'hFFFF, 32'hFFFF_FFFF, 20'd999999, 32'hFFFF_FFFF, 20'd999999);
        d.total_length = 16'hFFFF;
        d.header_words = 4'd0;
        queue_item(d);
        d = '0;
        queue_item(d);
        queue_item(echo_reply(16'd3, 32'd50, 20'd0, 32'd51, 20'd0));
        drain();

        write_reg(REG_MY_ID, 16'($urandom_range(1, 65534)));
        write_reg(REG_MIN_LENGTH, 16'($urandom_range(20, 100)));
        queue_random(560);
        drain();

        send_idle = 71;
        recv_idle = 24;
        write_reg(REG_MY_ID, 16'hFFFF);
        write_reg(REG_MIN_LENGTH, 16'h0000);
        queue_random(560);
        drain();

        write_reg(REG_MY_ID, 16'h0000);
        write_reg(REG_MIN_LENGTH, 16'hFFFF);
        queue_random(40);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_MY_ID, 16'($urandom));
        write_reg(REG_MIN_LENGTH, 16'd28);
        queue_random(560);
        drain();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && stats_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
